>>> rtl/rpl_pkg.sv
// ----------------------------------------------------------------------------
// rpl_pkg
// Shared types and constants of the region proximity load/enable block.
// ----------------------------------------------------------------------------
package rpl_pkg;

  localparam int MAX_ROOMS = 16;
  localparam int ROOM_W    = 4;   // width of a room index field
  localparam int CNT_W     = 5;   // width of the room count register
  localparam int COORD_W   = 16;
  localparam int HALF_W    = 12;
  localparam int BOUND_W   = COORD_W + 2;  // signed window edge
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;
  localparam int KIND_W    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 3'd0,
    KIND_ENABLE  = 3'd1,
    KIND_DISABLE = 3'd2,
    KIND_SAVE    = 3'd3,
    KIND_UNLOAD  = 3'd4,
    KIND_DONE    = 3'd5
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOM_COUNT    = 3'd0,
    CFG_LOAD_HALF_W   = 3'd1,
    CFG_LOAD_HALF_H   = 3'd2,
    CFG_ENABLE_HALF_W = 3'd3,
    CFG_ENABLE_HALF_H = 3'd4
  } cfg_index_e;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_CENTER = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [ROOM_W-1:0]  room_index;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_w;
    logic [COORD_W-1:0] rect_h;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } in_item_t;

  typedef struct packed {
    logic [ROOM_W-1:0] event_room;
    logic [KIND_W-1:0] event_kind;
    logic              last_event;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  // controller to datapath
  typedef struct packed {
    logic wr;         // store a rectangle
    logic start;      // latch windows, rewind room index
    logic rd;         // read table at current room
    logic advance;    // step room index and read the next entry
    logic eval;       // classify current room, update flags
    logic emit;       // send lowest pending event word
    logic emit_done;  // send closing word
  } rpl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic none;       // no rooms to walk
    logic is_last;    // current room is the final one
    logic pending;    // event words still to send for this room
    logic out_free;   // output register can take a word
  } rpl_status_t;

endpackage

>>> rtl/rpl_ram.sv
// ----------------------------------------------------------------------------
// rpl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rpl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rpl_datapath.sv
// ----------------------------------------------------------------------------
// rpl_datapath
// Room table, flags, window bounds, per-room classification and output word.
// ----------------------------------------------------------------------------
module rpl_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rpl_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  rpl_pkg::in_item_t             in_item_i,
  input  rpl_pkg::rpl_cmd_t             cmd_i,
  output rpl_pkg::rpl_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rpl_pkg::out_item_t            out_item_o
);
  import rpl_pkg::*;

  typedef logic signed [BOUND_W-1:0] bound_t;

  // configuration
  logic [CNT_W-1:0]  room_count_q;
  logic [HALF_W-1:0] load_hw_q, load_hh_q, en_hw_q, en_hh_q;

  // window bounds of the current centre
  bound_t lx_lo_q, lx_hi_q, ly_lo_q, ly_hi_q;
  bound_t ex_lo_q, ex_hi_q, ey_lo_q, ey_hi_q;
  logic   l_empty_q, e_empty_q;

  logic [ROOM_W-1:0]    idx_q;
  logic [MAX_ROOMS-1:0] loaded_q, enabled_q;

  // event words for the current room
  logic [KIND_W-1:0] slot_kind_q [3];
  logic [2:0]        pend_q;

  logic      out_valid_q;
  out_item_t out_item_q;

  logic [CNT_W-1:0]  count_eff;
  logic [ROOM_W-1:0] raddr;
  logic              ram_we, ram_re;
  logic [RECT_W-1:0] rdata;
  rect_t             room;
  logic              l_hit, e_hit, cur_loaded, cur_enabled;
  logic [1:0]        pick;
  logic              out_free;

  function automatic logic win_hit(rect_t r, bound_t xlo, bound_t xhi,
                                   bound_t ylo, bound_t yhi, logic empty);
    logic [COORD_W:0] r_right, r_bottom;
    logic             hx, hy;
    r_right  = {1'b0, r.left} + {1'b0, r.width};
    r_bottom = {1'b0, r.top} + {1'b0, r.height};
    hx = ($signed({2'b00, r.left}) < xhi) && (xlo < $signed({1'b0, r_right}));
    hy = ($signed({2'b00, r.top}) < yhi) && (ylo < $signed({1'b0, r_bottom}));
    return !empty && (r.width != '0) && (r.height != '0) && hx && hy;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_count_q <= '0;
      load_hw_q    <= HALF_W'(32);
      load_hh_q    <= HALF_W'(32);
      en_hw_q      <= HALF_W'(16);
      en_hh_q      <= HALF_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROOM_COUNT:    room_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_LOAD_HALF_W:   load_hw_q    <= cfg_data_i[HALF_W-1:0];
        CFG_LOAD_HALF_H:   load_hh_q    <= cfg_data_i[HALF_W-1:0];
        CFG_ENABLE_HALF_W: en_hw_q      <= cfg_data_i[HALF_W-1:0];
        CFG_ENABLE_HALF_H: en_hh_q      <= cfg_data_i[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // counts above the table size walk the whole table
  assign count_eff = (room_count_q > CNT_W'(MAX_ROOMS)) ? CNT_W'(MAX_ROOMS) : room_count_q;

  assign ram_we = cmd_i.wr && ({1'b0, in_item_i.room_index} < CNT_W'(MAX_ROOMS));
  assign ram_re = cmd_i.rd || cmd_i.advance;
  assign raddr  = cmd_i.advance ? idx_q + ROOM_W'(1) : idx_q;

  rpl_ram #(
    .Width (RECT_W),
    .Depth (MAX_ROOMS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_item_i.room_index),
    .wdata_i ({in_item_i.rect_x, in_item_i.rect_y, in_item_i.rect_w, in_item_i.rect_h}),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign room = rect_t'(rdata);

  // window bounds, latched once per centre
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lx_lo_q   <= $signed({2'b00, in_item_i.center_x}) - $signed({6'b0, load_hw_q});
      lx_hi_q   <= $signed({2'b00, in_item_i.center_x}) + $signed({6'b0, load_hw_q});
      ly_lo_q   <= $signed({2'b00, in_item_i.center_y}) - $signed({6'b0, load_hh_q});
      ly_hi_q   <= $signed({2'b00, in_item_i.center_y}) + $signed({6'b0, load_hh_q});
      ex_lo_q   <= $signed({2'b00, in_item_i.center_x}) - $signed({6'b0, en_hw_q});
      ex_hi_q   <= $signed({2'b00, in_item_i.center_x}) + $signed({6'b0, en_hw_q});
      ey_lo_q   <= $signed({2'b00, in_item_i.center_y}) - $signed({6'b0, en_hh_q});
      ey_hi_q   <= $signed({2'b00, in_item_i.center_y}) + $signed({6'b0, en_hh_q});
      l_empty_q <= (load_hw_q == '0) || (load_hh_q == '0);
      e_empty_q <= (en_hw_q == '0) || (en_hh_q == '0);
    end
  end

  assign l_hit       = win_hit(room, lx_lo_q, lx_hi_q, ly_lo_q, ly_hi_q, l_empty_q);
  assign e_hit       = win_hit(room, ex_lo_q, ex_hi_q, ey_lo_q, ey_hi_q, e_empty_q);
  assign cur_loaded  = loaded_q[idx_q];
  assign cur_enabled = enabled_q[idx_q];

  assign pick = pend_q[0] ? 2'd0 : (pend_q[1] ? 2'd1 : 2'd2);

  assign out_free = !out_valid_q || out_ready_i;

  // room index, flags and pending event marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      loaded_q  <= '0;
      enabled_q <= '0;
      pend_q    <= '0;
    end else begin
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.advance) begin
        idx_q <= idx_q + ROOM_W'(1);
      end
      if (cmd_i.eval) begin
        // enabled implies loaded, so the new flags follow from the hits alone
        loaded_q[idx_q]  <= l_hit;
        enabled_q[idx_q] <= l_hit && e_hit;
        if (l_hit) begin
          pend_q[0] <= !cur_loaded;
          pend_q[1] <= e_hit != cur_enabled;
          pend_q[2] <= 1'b0;
        end else begin
          pend_q[0] <= cur_loaded;
          pend_q[1] <= cur_loaded && cur_enabled;
          pend_q[2] <= cur_loaded;
        end
      end else if (cmd_i.emit) begin
        pend_q[pick] <= 1'b0;
      end
    end
  end

  // event kinds of the current room
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      if (l_hit) begin
        slot_kind_q[0] <= KIND_LOAD;
        slot_kind_q[1] <= e_hit ? KIND_ENABLE : KIND_DISABLE;
      end else begin
        slot_kind_q[0] <= KIND_SAVE;
        slot_kind_q[1] <= KIND_DISABLE;
      end
      slot_kind_q[2] <= KIND_UNLOAD;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_item_q.event_room <= idx_q;
      out_item_q.event_kind <= slot_kind_q[pick];
      out_item_q.last_event <= 1'b0;
    end else if (cmd_i.emit_done) begin
      out_item_q.event_room <= '0;
      out_item_q.event_kind <= KIND_DONE;
      out_item_q.last_event <= 1'b1;
    end
  end

  assign status_o.none     = (count_eff == '0);
  assign status_o.is_last  = (({1'b0, idx_q} + CNT_W'(1)) == count_eff);
  assign status_o.pending  = |pend_q;
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/rpl_ctrl.sv
// ----------------------------------------------------------------------------
// rpl_ctrl
// Sequencer for the room walk: read, classify, send events, close.
// ----------------------------------------------------------------------------
module rpl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  rpl_pkg::rpl_status_t status_i,
  output rpl_pkg::rpl_cmd_t    cmd_o
);
  import rpl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMIT,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr        = accept && (req_type_i == REQ_WRITE);
    cmd_o.start     = accept && (req_type_i == REQ_CENTER);
    cmd_o.rd        = (state_q == ST_READ);
    cmd_o.eval      = (state_q == ST_EVAL);
    cmd_o.emit      = (state_q == ST_EMIT) && status_i.pending && status_i.out_free;
    cmd_o.advance   = (state_q == ST_EMIT) && !status_i.pending && !status_i.is_last;
    cmd_o.emit_done = (state_q == ST_DONE) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (req_type_i == REQ_CENTER)) begin
            state_q <= status_i.none ? ST_DONE : ST_READ;
          end
        end
        ST_READ: state_q <= ST_EVAL;
        ST_EVAL: state_q <= ST_EMIT;
        ST_EMIT: begin
          // next entry is read in the same cycle the room is finished
          if (!status_i.pending) begin
            state_q <= status_i.is_last ? ST_DONE : ST_EVAL;
          end
        end
        ST_DONE: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/region_proximity_load_enable.sv
// ----------------------------------------------------------------------------
// region_proximity_load_enable
// Room table with load/enable tracking around a moving centre point.
// ----------------------------------------------------------------------------
// Input words (in_valid_i/in_ready_o) either store one room rectangle or give
// a new centre. A rectangle write is taken while idle and gives no output.
// A centre starts a walk over rooms 0 .. room_count-1, capped at the table
// size: each room is read from the table and classified, then a check for
// pending events sends each event word in turn, and the walk ends with a
// done word marked last. With room_count zero only the done word is sent.
// The walk uses the single table read port and sends every word through the
// one output register. in_ready_o is high only between walks.
// Output words (out_valid_o/out_ready_i) pass through one register; a stalled
// receiver holds the walk at the next event, and the block takes the next
// input word while the done word still waits.
// Reset clears the loaded and enabled flags and sets the configuration to
// its defaults; room rectangles hold no value until written. Configuration
// (cfg_we_i) is for the user to write between walks; the block does not enforce it.
// ----------------------------------------------------------------------------
module region_proximity_load_enable (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rpl_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rpl_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rpl_pkg::out_item_t            out_item_o
);
  import rpl_pkg::*;

  rpl_cmd_t    cmd;
  rpl_status_t status;

  rpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (in_item_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rpl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/rpl_checker.sv
// ----------------------------------------------------------------------------
// rpl_checker
// Port-level checks of the region proximity block, bound to the top level.
// ----------------------------------------------------------------------------
module rpl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input rpl_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rpl_pkg::out_item_t out_item_o
);
  import rpl_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output word changed while stalled");

  // last marks exactly the done word
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last_event == (out_item_o.event_kind == KIND_DONE)))
    else $error("last flag does not match done word");

  a_done_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_event |-> out_item_o.event_room == '0)
    else $error("done word carries a room");

  // a centre starts a walk, a rectangle write does not
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.req_type == REQ_CENTER) |=> !in_ready_o)
    else $error("input taken during a walk");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.req_type == REQ_WRITE) |=> in_ready_o)
    else $error("rectangle write left the block busy");

endmodule

bind region_proximity_load_enable rpl_checker u_rpl_checker (.*);
